// ===== sv/keyboard_scan_code_queue_assert.svh =====
// Assertion macros for the keyboard scan code queue.
`ifndef KEYBOARD_SCAN_CODE_QUEUE_ASSERT_SVH
`define KEYBOARD_SCAN_CODE_QUEUE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define KSCQ_ASSERT_IMM(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scan code queue check failed");

// Check that cons holds in the cycle after ante.
`define KSCQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scan code queue check failed");

`endif

// ===== sv/kscq_pkg.sv =====
// Shared types and constants for the keyboard scan code queue.
`default_nettype none

package kscq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam logic [7:0] CMD_RESET    = 8'o357;
   localparam logic [7:0] CMD_IDENT    = 8'o253;
   localparam logic [7:0] PACING_RESET = 8'd8;
   localparam int MAX_PUSH = 4;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_KEY  = 2'd1,
      OP_CMD  = 2'd2,
      OP_READ = 2'd3
   } op_type;

   // Up to four bytes written at consecutive ring positions in the same cycle.
   typedef struct packed {
      logic [2:0]                   cnt;
      logic [MAX_PUSH-1:0][7:0]     bytes;
   } push_type;

endpackage

`default_nettype wire

// ===== sv/kscq_store.sv =====
// Ring byte store: multi-byte write at the tail, read at the head.
`default_nettype none

module kscq_store
   import kscq_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] wr_base,
   input  wire push_type      wr,
   input  wire logic [AW-1:0] rd_idx,
   output logic [7:0]         rd_byte
);

   logic [7:0]    mem_ff [DEPTH];
   logic [AW-1:0] wr_idx [MAX_PUSH];

   // Wrap each successive write position around the ring.
   always_comb begin
      logic [AW:0] sum;
      for (int k = 0; k < MAX_PUSH; k++) begin
         sum = {1'b0, wr_base} + (AW+1)'(k);
         if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
         end
         wr_idx[k] = sum[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_PUSH; k++) begin
         if (wr.cnt > 3'(k)) begin
            mem_ff[wr_idx[k]] <= wr.bytes[k];
         end
      end
   end

   assign rd_byte = mem_ff[rd_idx];

endmodule

`default_nettype wire

// ===== sv/keyboard_scan_code_queue.sv =====
// Top level of the keyboard scan code queue with host-read pacing.
`default_nettype none

// Keyboard transmit byte queue. Each request item carries an opcode: a tick
// counts the pacing counter down towards zero, a key press appends its scan
// code, a host command byte either resets the queue (octal 357: empty it,
// clear head and pacing, then queue 1,0,0,0) or requests identification
// (octal 253: queue 1,0), and a host read removes the head byte and reloads
// the pacing counter from the pacing_ticks register. Every request item gives
// exactly one response item carrying the byte read (0 if none), the ready
// flag (pacing counter zero and queue not empty), the fill level and a drop
// flag for pushes lost to a full queue. An item is taken into an input
// register, worked on by combinational logic that updates the queue state,
// and leaves through a response register, so one item is accepted every
// clock cycle while the response register is not stalled. The input
// register holds while the response register is stalled. The byte
// store is a ring of QUEUE_DEPTH entries addressed by a head pointer; its
// entries carry no reset, and only bytes that were pushed are ever read.
// The pacing register may be written at any time on the csr channel, which
// is always ready; write it only while no request item is in flight.

module keyboard_scan_code_queue
   import kscq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte,
   output logic            rsp_byte_ready,
   output logic [4:0]      rsp_queue_count,
   output logic            rsp_dropped,
   // pacing register write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_pacing_ticks
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // input register
   logic          s1_valid_ff;
   op_type        s1_op_ff;
   logic [7:0]    s1_data_ff;

   // queue state
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [7:0]    pace_ff, pace_in;
   logic [7:0]    pacing_ticks_ff;

   // response register
   logic          rsp_valid_ff;
   logic [7:0]    rsp_read_byte_ff, rsp_read_byte_in;
   logic          rsp_byte_ready_ff, rsp_byte_ready_in;
   logic [4:0]    rsp_queue_count_ff, rsp_queue_count_in;
   logic          rsp_dropped_ff, rsp_dropped_in;

   logic          advance;
   logic          work;
   logic [AW-1:0] tail;
   logic [AW-1:0] wr_base;
   push_type      push;
   logic [7:0]    head_byte;

   // The response register frees up when empty or when its item is taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign work      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;

   // Take a new item whenever the input register moves on or is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff   <= op_type'(req_opcode);
         s1_data_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pacing_ticks_ff <= PACING_RESET;
      end else if (csr_valid && csr_ready) begin
         pacing_ticks_ff <= csr_pacing_ticks;
      end
   end

   // Tail position: head plus fill, wrapped round the ring.
   always_comb begin
      logic [AW:0] sum;
      sum = {1'b0, head_ff} + (AW+1)'(fill_ff);
      if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AW+1)'(QUEUE_DEPTH);
      end
      tail = sum[AW-1:0];
   end

   // One step of the queue: decide the pushes, the pop and the new counters.
   always_comb begin
      logic [AW:0] head_next;
      head_in          = head_ff;
      fill_in          = fill_ff;
      pace_in          = pace_ff;
      wr_base          = tail;
      push.cnt         = 3'd0;
      push.bytes       = '0;
      rsp_read_byte_in = 8'd0;
      rsp_dropped_in   = 1'b0;
      head_next        = {1'b0, head_ff} + (AW+1)'(1);
      if (head_next >= (AW+1)'(QUEUE_DEPTH)) begin
         head_next = '0;
      end
      case (s1_op_ff)
         OP_TICK: begin
            if (pace_ff != 8'd0) begin
               pace_in = pace_ff - 8'd1;
            end
         end
         OP_KEY: begin
            if (fill_ff >= CW'(QUEUE_DEPTH)) begin
               rsp_dropped_in = 1'b1;
            end else begin
               push.cnt      = 3'd1;
               push.bytes[0] = s1_data_ff;
               fill_in       = fill_ff + CW'(1);
            end
         end
         OP_CMD: begin
            if (s1_data_ff == CMD_RESET) begin
               // Empty the queue, then queue the reset reply from slot zero.
               head_in       = '0;
               pace_in       = 8'd0;
               wr_base       = '0;
               push.cnt      = 3'd4;
               push.bytes[0] = 8'd1;
               fill_in       = CW'(4);
            end else if (s1_data_ff == CMD_IDENT) begin
               push.bytes[0] = 8'd1;
               if ((CW+1)'(fill_ff) + (CW+1)'(2) <= (CW+1)'(QUEUE_DEPTH)) begin
                  push.cnt = 3'd2;
                  fill_in  = fill_ff + CW'(2);
               end else if (fill_ff < CW'(QUEUE_DEPTH)) begin
                  push.cnt       = 3'd1;
                  fill_in        = fill_ff + CW'(1);
                  rsp_dropped_in = 1'b1;
               end else begin
                  rsp_dropped_in = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (fill_ff != '0) begin
               rsp_read_byte_in = head_byte;
               head_in          = head_next[AW-1:0];
               fill_in          = fill_ff - CW'(1);
               pace_in          = pacing_ticks_ff;
            end
         end
         default: begin
         end
      endcase
      if (!work) begin
         push.cnt = 3'd0;
      end
      rsp_byte_ready_in  = (pace_in == 8'd0) && (fill_in != '0);
      rsp_queue_count_in = 5'(fill_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         pace_ff <= 8'd0;
      end else if (work) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         pace_ff <= pace_in;
      end
   end

   // Load the response register when it frees up; hold it while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (work) begin
         rsp_read_byte_ff   <= rsp_read_byte_in;
         rsp_byte_ready_ff  <= rsp_byte_ready_in;
         rsp_queue_count_ff <= rsp_queue_count_in;
         rsp_dropped_ff     <= rsp_dropped_in;
      end
   end

   kscq_store #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_base (wr_base),
      .wr      (push),
      .rd_idx  (head_ff),
      .rd_byte (head_byte)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_byte   = rsp_read_byte_ff;
   assign rsp_byte_ready  = rsp_byte_ready_ff;
   assign rsp_queue_count = rsp_queue_count_ff;
   assign rsp_dropped     = rsp_dropped_ff;

   `include "keyboard_scan_code_queue_assert.svh"

   `KSCQ_ASSERT_IMM(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(QUEUE_DEPTH))
   `KSCQ_ASSERT_IMM(a_ready_needs_bytes, clock, reset,
      rsp_valid_ff && rsp_byte_ready_ff, rsp_queue_count_ff != 5'd0)
   `KSCQ_ASSERT_IMM(a_drop_means_full, clock, reset,
      rsp_valid_ff && rsp_dropped_ff, fill_ff == CW'(QUEUE_DEPTH))
   `KSCQ_ASSERT_NEXT(a_reset_cmd, clock, reset,
      work && s1_op_ff == OP_CMD && s1_data_ff == CMD_RESET,
      fill_ff == CW'(4) && head_ff == '0 && pace_ff == 8'd0)

endmodule

`default_nettype wire
